### hw/rtl/bprq_pkg.sv
// Shared definitions for the bucketed priority ready queue: parameter defaults,
// field widths, action codes, the cell write-enable group and sequencer states.
// No dependencies.
`default_nettype none

package bprq_pkg;

    // Parameter defaults
    localparam int THREADS_DEF = 32;
    localparam int LEVELS_DEF  = 32;
    localparam int BUCKETS_DEF = 8;

    // Fixed field widths of the request and response
    localparam int ACT_W  = 2;
    localparam int TID_W  = 5;
    localparam int PRIO_W = 5;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_ROTATE = 2'd3;

    // Field enables of one write into the cell row
    typedef struct packed {
        logic en_next;
        logic en_prev;
        logic en_prio;
    } cell_wr_t;

    // Sequencer states, one-hot
    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_PEEK    = 13'b0000000000010,
        S_INS     = 13'b0000000000100,
        S_WALK    = 13'b0000000001000,
        S_LINK_A  = 13'b0000000010000,
        S_LINK_B  = 13'b0000000100000,
        S_LINK_C  = 13'b0000001000000,
        S_LOOK    = 13'b0000010000000,
        S_DECIDE  = 13'b0000100000000,
        S_UNL_A   = 13'b0001000000000,
        S_UNL_B   = 13'b0010000000000,
        S_ROT_ADV = 13'b0100000000000,
        S_RESP    = 13'b1000000000000
    } seq_state_t;

endpackage

`default_nettype wire

### hw/rtl/bprq_cell.sv
// One thread entry of the ready queue: next link, previous link and priority.
// Joins the read chain of the cell row. Depends on bprq_pkg.
`default_nettype none

module bprq_cell
    import bprq_pkg::*;
#(
    parameter int TW  = $clog2(THREADS_DEF),
    parameter int IDX = 0
)
(
    input  logic                     clk,
    input  logic [TW-1:0]            rd_addr,
    input  logic [TW-1:0]            wr_addr,
    input  cell_wr_t                 wr_ctl,
    input  logic [TW-1:0]            wr_next,
    input  logic [TW-1:0]            wr_prev,
    input  logic [PRIO_W-1:0]        wr_prio,
    input  logic [2*TW+PRIO_W-1:0]   chain_in,
    output logic [2*TW+PRIO_W-1:0]   chain_out
);

    logic [TW-1:0]     next_reg;
    logic [TW-1:0]     prev_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic              wr_hit;
    logic              rd_hit;

    assign wr_hit = (wr_addr == TW'(IDX));
    assign rd_hit = (rd_addr == TW'(IDX));

    always_ff @(posedge clk)
    begin
        if (wr_hit && wr_ctl.en_next)
        begin
            next_reg <= wr_next;
        end
        if (wr_hit && wr_ctl.en_prev)
        begin
            prev_reg <= wr_prev;
        end
        if (wr_hit && wr_ctl.en_prio)
        begin
            prio_reg <= wr_prio;
        end
    end

    // merge own entry into the chain when addressed
    assign chain_out = chain_in | (rd_hit ? {next_reg, prev_reg, prio_reg} : '0);

endmodule

`default_nettype wire

### hw/rtl/bucketed_priority_ready_queue.sv
// Top level of the bucketed priority ready queue: list sequencer, bucket table,
// used-bucket bitmap and response register over a row of bprq_cell entries.
// Depends on bprq_pkg and bprq_cell.
//
// Usage:
//   Request channel (req_valid / req_stall) carries action, thread_id and
//   priority_req. Response channel (rsp_valid / rsp_stall) returns one
//   head_thread / head_valid pair for every request, in request order.
//   Each thread owns one cell holding its links and priority; the sequencer
//   reads one cell and writes one cell per cycle over the row.
// Steps: peek reads the bitmap, a thread id out of range goes straight to the
//   response, remove looks up the cell and unlinks it, insert into an empty
//   bucket writes the cell at once, other inserts and rotates walk the bucket
//   list, one entry per cycle; with one level per bucket a rotate only moves
//   the bucket head on. One request is in work at a time; the next is taken
//   once the sequencer is back in the idle state after the previous response is loaded.
// Stall: the response register holds while rsp_stall is high; a new request
//   is still accepted and worked on, and waits to load until the register frees.
// Reset: the used-bucket bitmap clears, so the queue starts empty. Cells and
//   bucket heads are written before they are read and need no clearing.
`default_nettype none

module bucketed_priority_ready_queue
    import bprq_pkg::*;
#(
    parameter int THREADS = THREADS_DEF,
    parameter int LEVELS  = LEVELS_DEF,
    parameter int BUCKETS = BUCKETS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [ACT_W-1:0]  action,
    input  logic [TID_W-1:0]  thread_id,
    input  logic [PRIO_W-1:0] priority_req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [TID_W-1:0]  head_thread,
    output logic              head_valid
);

    localparam int TW         = $clog2(THREADS);
    localparam int BW         = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int DW         = 2 * TW + PRIO_W;
    localparam int PER        = (LEVELS + BUCKETS - 1) / BUCKETS;
    localparam int SHIFT      = $clog2(PER + 1) - 1;
    localparam int TCMP_W     = ((TW + 1 > TID_W) ? (TW + 1) : TID_W) + 1;
    localparam int BCMP_W     = ((BW > PRIO_W) ? BW : PRIO_W) + 1;
    localparam bit ROT_SIMPLE = (BUCKETS == LEVELS);

    // Map a priority to its bucket by the top bits, saturating at the last one
    function automatic logic [BW-1:0] bucket_of(input logic [PRIO_W-1:0] prio);
        logic [PRIO_W-1:0] sh;
        sh = prio >> SHIFT;
        if (BCMP_W'(sh) > BCMP_W'(BUCKETS - 1))
        begin
            return BW'(BUCKETS - 1);
        end
        return BW'(sh);
    endfunction

    // Control state
    seq_state_t         state_reg, state_next;
    logic [BUCKETS-1:0] used_reg, used_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Work registers
    logic [TW-1:0]      bhead_reg [BUCKETS];
    logic [TW-1:0]      bhead_next [BUCKETS];
    logic [ACT_W-1:0]   act_reg, act_next;
    logic [TW-1:0]      tid_reg, tid_next;
    logic [PRIO_W-1:0]  prio_reg, prio_next;
    logic [BW-1:0]      bkt_reg, bkt_next;
    logic [TW-1:0]      head_reg, head_next;
    logic [TW-1:0]      e_reg, e_next;
    logic [TW-1:0]      p_reg, p_next;
    logic [TW-1:0]      n_reg, n_next;
    logic [TW-1:0]      cnt_reg, cnt_next;
    logic               hdlt_reg, hdlt_next;
    logic [TID_W-1:0]   res_thread_reg, res_thread_next;
    logic               res_valid_reg, res_valid_next;
    logic [TID_W-1:0]   head_thread_reg, head_thread_next;
    logic               head_valid_reg, head_valid_next;

    // Cell row ports
    logic [TW-1:0]      rd_addr;
    logic [TW-1:0]      wr_addr;
    cell_wr_t           wr_ctl;
    logic [TW-1:0]      wr_next;
    logic [TW-1:0]      wr_prev;
    logic [PRIO_W-1:0]  wr_prio;
    logic [DW-1:0]      rd_chain [THREADS+1];
    logic [TW-1:0]      rd_next;
    logic [TW-1:0]      rd_prev;
    logic [PRIO_W-1:0]  rd_prio;

    logic [BW-1:0]      top_bkt;
    logic               t_ok;
    logic               rsp_free;

    // ---------------------------------------------------------------
    // Cell row: each cell ORs its entry into the chain when addressed
    // ---------------------------------------------------------------
    assign rd_chain[0] = '0;

    for (genvar gi = 0; gi < THREADS; gi++)
    begin : g_cell
        bprq_cell #(
            .TW  (TW),
            .IDX (gi)
        ) u_cell (
            .clk       (clk),
            .rd_addr   (rd_addr),
            .wr_addr   (wr_addr),
            .wr_ctl    (wr_ctl),
            .wr_next   (wr_next),
            .wr_prev   (wr_prev),
            .wr_prio   (wr_prio),
            .chain_in  (rd_chain[gi]),
            .chain_out (rd_chain[gi+1])
        );
    end

    assign rd_next = rd_chain[THREADS][DW-1 -: TW];
    assign rd_prev = rd_chain[THREADS][PRIO_W+TW-1 -: TW];
    assign rd_prio = rd_chain[THREADS][PRIO_W-1:0];

    // Highest used bucket for peek
    always_comb
    begin
        top_bkt = '0;
        for (int i = 0; i < BUCKETS; i++)
        begin
            if (used_reg[i])
            begin
                top_bkt = BW'(i);
            end
        end
    end

    assign t_ok      = (TCMP_W'(thread_id) < TCMP_W'(THREADS));
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);

    // Cell read address: one entry per cycle
    always_comb
    begin
        case (state_reg)
            S_LOOK:    rd_addr = tid_reg;
            S_ROT_ADV: rd_addr = bhead_reg[bkt_reg];
            default:   rd_addr = e_reg;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        bhead_next       = bhead_reg;
        act_next         = act_reg;
        tid_next         = tid_reg;
        prio_next        = prio_reg;
        bkt_next         = bkt_reg;
        head_next        = head_reg;
        e_next           = e_reg;
        p_next           = p_reg;
        n_next           = n_reg;
        cnt_next         = cnt_reg;
        hdlt_next        = hdlt_reg;
        res_thread_next  = res_thread_reg;
        res_valid_next   = res_valid_reg;
        head_thread_next = head_thread_reg;
        head_valid_next  = head_valid_reg;
        wr_addr          = tid_reg;
        wr_ctl           = '0;
        wr_next          = tid_reg;
        wr_prev          = tid_reg;
        wr_prio          = prio_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next        = action;
                    tid_next        = TW'(thread_id);
                    prio_next       = priority_req;
                    bkt_next        = bucket_of(priority_req);
                    res_thread_next = '0;
                    res_valid_next  = 1'b0;
                    if (action == ACT_PEEK)
                    begin
                        state_next = S_PEEK;
                    end
                    else if (!t_ok)
                    begin
                        state_next = S_RESP;
                    end
                    else if (action == ACT_INSERT)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end

            S_PEEK:
            begin
                if (|used_reg)
                begin
                    res_thread_next = TID_W'(bhead_reg[top_bkt]);
                    res_valid_next  = 1'b1;
                end
                state_next = S_RESP;
            end

            S_INS:
            begin
                // store the priority; an empty bucket takes the thread alone
                wr_addr        = tid_reg;
                wr_ctl.en_prio = 1'b1;
                if (!used_reg[bkt_reg])
                begin
                    wr_ctl.en_next      = 1'b1;
                    wr_ctl.en_prev      = 1'b1;
                    bhead_next[bkt_reg] = tid_reg;
                    used_next[bkt_reg]  = 1'b1;
                    state_next          = S_RESP;
                end
                else
                begin
                    head_next  = bhead_reg[bkt_reg];
                    e_next     = bhead_reg[bkt_reg];
                    cnt_next   = '0;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                // first step reads the head: remember whether it loses to us
                if (cnt_reg == '0)
                begin
                    hdlt_next = (rd_prio < prio_reg);
                end
                if (rd_prio < prio_reg)
                begin
                    state_next = S_LINK_A;
                end
                else if (rd_next == head_reg || cnt_reg == TW'(THREADS - 1))
                begin
                    e_next     = head_reg;
                    state_next = S_LINK_A;
                end
                else
                begin
                    e_next   = rd_next;
                    cnt_next = cnt_reg + TW'(1);
                end
            end

            S_LINK_A:
            begin
                // thread goes in before the slot entry
                wr_addr        = tid_reg;
                wr_ctl.en_next = 1'b1;
                wr_ctl.en_prev = 1'b1;
                wr_next        = e_reg;
                wr_prev        = rd_prev;
                p_next         = rd_prev;
                if (hdlt_reg)
                begin
                    bhead_next[bkt_reg] = tid_reg;
                end
                state_next = S_LINK_B;
            end

            S_LINK_B:
            begin
                wr_addr        = p_reg;
                wr_ctl.en_next = 1'b1;
                wr_next        = tid_reg;
                state_next     = S_LINK_C;
            end

            S_LINK_C:
            begin
                wr_addr        = e_reg;
                wr_ctl.en_prev = 1'b1;
                wr_prev        = tid_reg;
                if (act_reg == ACT_ROTATE)
                begin
                    res_thread_next = TID_W'(bhead_reg[bkt_reg]);
                    res_valid_next  = 1'b1;
                end
                state_next = S_RESP;
            end

            S_LOOK:
            begin
                n_next     = rd_next;
                p_next     = rd_prev;
                prio_next  = rd_prio;
                bkt_next   = bucket_of(rd_prio);
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                if (!used_reg[bkt_reg])
                begin
                    state_next = S_RESP;
                end
                else if (act_reg == ACT_REMOVE)
                begin
                    if (n_reg == tid_reg)
                    begin
                        used_next[bkt_reg] = 1'b0;
                        state_next         = S_RESP;
                    end
                    else
                    begin
                        if (bhead_reg[bkt_reg] == tid_reg)
                        begin
                            bhead_next[bkt_reg] = n_reg;
                        end
                        state_next = S_UNL_A;
                    end
                end
                else if (n_reg == tid_reg)
                begin
                    // lone thread: nothing moves
                    res_thread_next = TID_W'(bhead_reg[bkt_reg]);
                    res_valid_next  = 1'b1;
                    state_next      = S_RESP;
                end
                else if (ROT_SIMPLE)
                begin
                    state_next = S_ROT_ADV;
                end
                else
                begin
                    bhead_next[bkt_reg] = n_reg;
                    state_next          = S_UNL_A;
                end
            end

            S_UNL_A:
            begin
                wr_addr        = p_reg;
                wr_ctl.en_next = 1'b1;
                wr_next        = n_reg;
                state_next     = S_UNL_B;
            end

            S_UNL_B:
            begin
                wr_addr        = n_reg;
                wr_ctl.en_prev = 1'b1;
                wr_prev        = p_reg;
                if (act_reg == ACT_REMOVE)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    // re-insert behind equals, walking from the new head
                    head_next  = n_reg;
                    e_next     = n_reg;
                    cnt_next   = '0;
                    state_next = S_WALK;
                end
            end

            S_ROT_ADV:
            begin
                bhead_next[bkt_reg] = rd_next;
                res_thread_next     = TID_W'(rd_next);
                res_valid_next      = 1'b1;
                state_next          = S_RESP;
            end

            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next   = 1'b1;
                    head_thread_next = res_thread_reg;
                    head_valid_next  = res_valid_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bhead_reg       <= bhead_next;
        act_reg         <= act_next;
        tid_reg         <= tid_next;
        prio_reg        <= prio_next;
        bkt_reg         <= bkt_next;
        head_reg        <= head_next;
        e_reg           <= e_next;
        p_reg           <= p_next;
        n_reg           <= n_next;
        cnt_reg         <= cnt_next;
        hdlt_reg        <= hdlt_next;
        res_thread_reg  <= res_thread_next;
        res_valid_reg   <= res_valid_next;
        head_thread_reg <= head_thread_next;
        head_valid_reg  <= head_valid_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign head_thread = head_thread_reg;
    assign head_valid  = head_valid_reg;

`ifndef SYNTHESIS
    // a response appears only out of the response state
    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_RESP))
        else $error("response raised outside the response state");

    // insert into an empty bucket marks it used
    a_ins_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS && !used_reg[bkt_reg]) |=> used_reg[$past(bkt_reg)])
        else $error("insert into empty bucket left its bit clear");

    // bitmap moves only on insert or on the remove decision
    a_bitmap_src: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg))
            |-> ($past(state_reg) == S_INS || $past(state_reg) == S_DECIDE))
        else $error("used-bucket bitmap changed outside insert or remove");

    // peek reports valid exactly when some bucket is used
    a_peek_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PEEK) |=> (res_valid_reg == $past(|used_reg)))
        else $error("peek validity disagrees with bitmap");
`endif

endmodule

`default_nettype wire

### dv/bucketed_priority_ready_queue_tb.sv
// Self-checking testbench for the bucketed priority ready queue: directed and random
// insert, remove, peek and rotate requests, checked against an in-bench list model.
// Depends on bprq_pkg and the bucketed_priority_ready_queue RTL.
`timescale 1ns / 1ps

module bucketed_priority_ready_queue_tb
    import bprq_pkg::*;
();

    localparam int N_THREADS      = THREADS_DEF;
    localparam int N_LEVELS       = LEVELS_DEF;
    localparam int N_BUCKETS      = BUCKETS_DEF;
    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int WATCHDOG_LIMIT = 2000;
    // Longest request in work (rotate over a full bucket) plus margin.
    localparam int DRAIN_CYCLES   = N_THREADS + 30;

    // One response: the head thread and whether it means anything.
    typedef struct packed {
        logic [TID_W-1:0] head;
        logic             valid;
    } head_t;

    // Scoreboard: mirrors the per-thread links, priorities, bucket heads and the
    // used-bucket bitmap, and queues the head that each accepted request yields.
    class ready_queue_scoreboard;
        logic [TID_W-1:0]     next_link   [N_THREADS];
        logic [TID_W-1:0]     prev_link   [N_THREADS];
        logic [PRIO_W-1:0]    thread_prio [N_THREADS];
        logic [TID_W-1:0]     bucket_head [N_BUCKETS];
        logic [N_BUCKETS-1:0] bucket_used;
        head_t                expected_heads [$];
        int                   mismatches;

        function new();
            bucket_used = '0;
            mismatches  = 0;
        endfunction

        function int bucket_of(logic [PRIO_W-1:0] pr);
            int per;
            int s;
            int b;
            per = (N_LEVELS + N_BUCKETS - 1) / N_BUCKETS;
            s = 0;
            while (s < 31 && (per >> (s + 1)) != 0)
                s++;
            b = int'(pr) >> s;
            return (b < N_BUCKETS) ? b : N_BUCKETS - 1;
        endfunction

        function void link_before(int e, int t);
            int p;
            p = prev_link[e];
            next_link[t] = TID_W'(e);
            prev_link[t] = TID_W'(p);
            next_link[p] = TID_W'(t);
            prev_link[e] = TID_W'(t);
        endfunction

        function void unlink(int t);
            int n;
            int p;
            n = next_link[t];
            p = prev_link[t];
            next_link[p] = TID_W'(n);
            prev_link[n] = TID_W'(p);
        endfunction

        // First entry below pr, or the head when none is lower; give up after
        // one lap's worth of steps so a broken list cannot hang the walk.
        function int find_slot(int b, logic [PRIO_W-1:0] pr);
            int head;
            int e;
            head = bucket_head[b];
            e = head;
            for (int i = 0; i < N_THREADS; i++)
            begin
                if (thread_prio[e] < pr)
                    return e;
                e = next_link[e];
                if (e == head)
                    return head;
            end
            return head;
        endfunction

        // Apply one request to the mirrored state and return the head it yields.
        function head_t predict_head(logic [ACT_W-1:0] act, logic [TID_W-1:0] tid,
                                     logic [PRIO_W-1:0] pr);
            head_t r;
            int    t;
            int    b;
            int    e;
            r = '0;
            t = int'(tid);
            if (act == ACT_PEEK)
            begin
                for (int i = N_BUCKETS - 1; i >= 0; i--)
                begin
                    if (bucket_used[i])
                    begin
                        r.head  = bucket_head[i];
                        r.valid = 1'b1;
                        break;
                    end
                end
                return r;
            end
            if (t >= N_THREADS)
                return r;
            if (act == ACT_INSERT)
            begin
                b = bucket_of(pr);
                thread_prio[t] = pr;
                if (!bucket_used[b])
                begin
                    bucket_head[b] = tid;
                    next_link[t]   = tid;
                    prev_link[t]   = tid;
                    bucket_used[b] = 1'b1;
                end
                else
                begin
                    e = find_slot(b, pr);
                    if (thread_prio[bucket_head[b]] < pr)
                        bucket_head[b] = tid;
                    link_before(e, t);
                end
                return r;
            end
            b = bucket_of(thread_prio[t]);
            if (!bucket_used[b])
                return r;
            if (act == ACT_REMOVE)
            begin
                if (int'(next_link[t]) == t)
                    bucket_used[b] = 1'b0;
                else
                begin
                    if (int'(bucket_head[b]) == t)
                        bucket_head[b] = next_link[t];
                    unlink(t);
                end
                return r;
            end
            // Rotate: move the thread behind its equals, or just advance the head.
            if (int'(next_link[t]) != t)
            begin
                if (N_BUCKETS == N_LEVELS)
                    bucket_head[b] = next_link[bucket_head[b]];
                else
                begin
                    bucket_head[b] = next_link[t];
                    unlink(t);
                    e = find_slot(b, thread_prio[t]);
                    if (thread_prio[bucket_head[b]] < thread_prio[t])
                        bucket_head[b] = tid;
                    link_before(e, t);
                end
            end
            r.head  = bucket_head[b];
            r.valid = 1'b1;
            return r;
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic [TID_W-1:0] tid,
                                   logic [PRIO_W-1:0] pr);
            expected_heads.push_back(predict_head(act, tid, pr));
        endfunction

        function void check_response(logic [TID_W-1:0] head, logic valid);
            head_t exp_head;
            if (expected_heads.size() == 0)
            begin
                $error("response with no request pending: head_thread %0d head_valid %0d",
                       head, valid);
                mismatches++;
                return;
            end
            exp_head = expected_heads.pop_front();
            if (valid !== exp_head.valid)
            begin
                $error("head_valid: expected %0d, actual %0d", exp_head.valid, valid);
                mismatches++;
            end
            if (head !== exp_head.head)
            begin
                $error("head_thread: expected %0d, actual %0d", exp_head.head, head);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_heads.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic [ACT_W-1:0]  action;
    logic [TID_W-1:0]  thread_id;
    logic [PRIO_W-1:0] priority_req;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [TID_W-1:0]  head_thread;
    logic              head_valid;

    ready_queue_scoreboard sb = new();

    // Stimulus-side view of the queue, used only to shape well-formed requests.
    bit queued  [N_THREADS];
    bit written [N_THREADS];
    bit no_gaps;
    int quiet_cycles;

    bucketed_priority_ready_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .thread_id    (thread_id),
        .priority_req (priority_req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .head_thread  (head_thread),
        .head_valid   (head_valid)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Idle with a chance of 13 in a hundred, except inside the gap-free stretch.
    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < 13);
    endfunction

    // Throttle the response side at the falling edge.
    always @(negedge clk)
    begin
        rsp_stall = take_gap();
    end

    // Sample both handshakes at the rising edge; note requests, check responses
    // and count cycles in which nothing moves for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            sb.note_request(action, thread_id, priority_req);
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(head_thread, head_valid);
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Drive one request; start and return at a falling edge. Hold the payload
    // steady until the request is taken.
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [TID_W-1:0] tid,
                                input logic [PRIO_W-1:0] pr);
        while (take_gap())
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        action       = act;
        thread_id    = tid;
        priority_req = pr;
        req_valid    = 1'b1;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        @(negedge clk);
    endtask

    // Track membership for later stimulus, then send.
    task automatic issue(input logic [ACT_W-1:0] act, input int tid, input int pr);
        if (act == ACT_INSERT)
        begin
            queued[tid]  = 1'b1;
            written[tid] = 1'b1;
        end
        else if (act == ACT_REMOVE)
            queued[tid] = 1'b0;
        send_request(act, TID_W'(tid), PRIO_W'(pr));
    endtask

    // Find a thread with the wanted membership, scanning from a random start.
    function automatic int find_thread(bit want_queued, bit need_written);
        int start;
        int idx;
        start = $urandom_range(N_THREADS - 1);
        for (int k = 0; k < N_THREADS; k++)
        begin
            idx = (start + k) % N_THREADS;
            if (queued[idx] == want_queued && (!need_written || written[idx]))
                return idx;
        end
        return -1;
    endfunction

    function automatic int queued_count();
        int c;
        c = 0;
        for (int i = 0; i < N_THREADS; i++)
            c += queued[i];
        return c;
    endfunction

    // Half the priorities come from a few crowded levels so that equal
    // priorities and mixed levels share a bucket often.
    function automatic int pick_priority();
        if ($urandom_range(1))
            return $urandom_range(31);
        return $urandom_range(1) ? 4 + $urandom_range(1) : 30 + $urandom_range(1);
    endfunction

    // Watchdog: end the run when nothing has moved for too long.
    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [ACT_W-1:0] act;
        int               tid;
        int               r;
        int               fill_w;
        int               drain_w;
        bit               fill_mode;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        action       = ACT_INSERT;
        thread_id    = '0;
        priority_req = '0;
        rsp_stall    = 1'b0;
        no_gaps      = 1'b0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty peek, both field extremes, head changes, FIFO among
        // equals, rotate of a lone thread, bucket emptying, unused bucket.
        issue(ACT_PEEK,   $urandom_range(31), $urandom_range(31));
        issue(ACT_INSERT, 0, 31);
        issue(ACT_INSERT, 31, 0);
        issue(ACT_INSERT, 1, 31);   // equal priority: queue behind thread 0
        issue(ACT_INSERT, 2, 28);   // lower: goes to the tail
        issue(ACT_INSERT, 3, 30);   // lands between the equals and the tail
        issue(ACT_INSERT, 4, 5);
        issue(ACT_INSERT, 5, 7);    // higher than the head: takes over the bucket
        issue(ACT_PEEK,   0, 0);
        issue(ACT_ROTATE, 0, 0);    // head moves on to its equal
        issue(ACT_ROTATE, 31, 31);  // alone in its bucket: nothing changes
        issue(ACT_ROTATE, 4, 0);
        issue(ACT_ROTATE, 2, 0);
        issue(ACT_REMOVE, 1, 0);    // drop the head
        issue(ACT_REMOVE, 31, 0);   // last one out: bucket empties
        issue(ACT_PEEK,   31, 31);
        issue(ACT_ROTATE, 31, 0);   // bucket no longer used
        issue(ACT_REMOVE, 31, 31);
        issue(ACT_REMOVE, 0, 0);
        issue(ACT_REMOVE, 3, 0);
        issue(ACT_REMOVE, 2, 0);
        issue(ACT_REMOVE, 5, 0);
        issue(ACT_REMOVE, 4, 0);
        issue(ACT_PEEK,   31, 31);

        // Random: alternate fill and drain phases of well-formed requests; hold
        // a gap-free stretch in the middle; mix in duplicate inserts and
        // removes/rotates of absent threads only near the end.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps   = (n >= 800 && n < 1100);
            fill_mode = ((n / 200) % 2) == 0;
            fill_w    = fill_mode ? 45 : 15;
            drain_w   = fill_mode ? 15 : 45;
            r         = $urandom_range(99);
            tid       = -1;
            if (n >= 1800 && r < 20)
            begin
                if ($urandom_range(2) == 0)
                begin
                    act = ACT_INSERT;
                    tid = find_thread(1'b1, 1'b1);
                end
                else
                begin
                    act = $urandom_range(1) ? ACT_REMOVE : ACT_ROTATE;
                    tid = find_thread(1'b0, 1'b1);
                end
            end
            else
            begin
                if (r < 15)
                    act = ACT_PEEK;
                else if (r < 15 + fill_w)
                    act = ACT_INSERT;
                else if (r < 15 + fill_w + drain_w)
                    act = ACT_REMOVE;
                else
                    act = ACT_ROTATE;
                if (act == ACT_INSERT && queued_count() == N_THREADS)
                    act = ACT_ROTATE;
                if ((act == ACT_REMOVE || act == ACT_ROTATE) && queued_count() == 0)
                    act = ACT_INSERT;
                if (act == ACT_INSERT)
                    tid = find_thread(1'b0, 1'b0);
                else if (act != ACT_PEEK)
                    tid = find_thread(1'b1, 1'b1);
            end
            if (act == ACT_PEEK || tid < 0)
                issue(ACT_PEEK, $urandom_range(31), $urandom_range(31));
            else if (act == ACT_INSERT)
                issue(act, tid, pick_priority());
            else
                issue(act, tid, $urandom_range(31));
        end
        req_valid = 1'b0;
        no_gaps   = 1'b0;

        // Drain: wait for every expected head, then watch for strays.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
